/* rtl/core/ackermann_command_converter_top_macros.svh */
// assertion macros for the ackermann command converter
`ifndef ACKERMANN_COMMAND_CONVERTER_TOP_MACROS_SVH
`define ACKERMANN_COMMAND_CONVERTER_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define ACC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ACC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/acc_pkg.sv */
// shared types and constants for the ackermann command converter
`default_nettype none
package acc_pkg;
    localparam int ANG_LEN = 24;
    localparam int ZW = 26;
    localparam logic [6:0] STEER_CAP = 7'd89;
    localparam logic [16:0] MAG_LIMIT = 17'd32768;

    typedef enum logic [1:0] {
        ACT_STOP = 2'd0,
        ACT_FWD = 2'd1,
        ACT_REV = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_WHEELBASE = 3'd0,
        REG_MAX_SPEED = 3'd1,
        REG_DEADBAND = 3'd2,
        REG_MAX_STEER = 3'd3,
        REG_RAW_SCALE = 3'd4,
        REG_STEER_INV = 3'd5
    } reg_idx_t;

    // classified command handed from front to back
    typedef struct packed {
        logic        stop;
        logic        neg;
        logic [15:0] absv;
        logic signed [15:0] speed;
        logic signed [15:0] yaw;
    } cmd_t;

    // atan(2^-i) in degrees, q16
    function automatic logic signed [ZW-1:0] ang_tab(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
                3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
                6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
                9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
                12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
                15: r = 26'sd115;     16: r = 26'sd57;      17: r = 26'sd29;
                18: r = 26'sd14;      19: r = 26'sd7;       20: r = 26'sd4;
                21: r = 26'sd2;       22: r = 26'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/acc_front.sv */
// front end: speed clamp and stop classification
`default_nettype none
module acc_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] speed,
    input  wire logic signed [15:0] yaw,
    input  wire logic [14:0]        max_speed,
    input  wire logic [9:0]         deadband,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output acc_pkg::cmd_t           out_cmd
);
    logic                 valid_reg;
    acc_pkg::cmd_t        cmd_reg, cmd_next;
    logic signed [16:0]   v, lim;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cmd = cmd_reg;

    always_comb begin
        lim = {2'b00, max_speed};
        v = 17'(speed);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        cmd_next.neg = v[16];
        cmd_next.absv = v[16] ? 16'(-v) : v[15:0];
        cmd_next.speed = v[15:0];
        cmd_next.yaw = yaw;
        cmd_next.stop = (cmd_next.absv == 16'd0) || (cmd_next.absv < {6'd0, deadband});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/acc_queue.sv */
// two-entry queue between front and back
`default_nettype none
module acc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire acc_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output acc_pkg::cmd_t      out_cmd
);
    acc_pkg::cmd_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

/* rtl/core/acc_back.sv */
// back end: pipelined cordic steering and drive magnitude
`default_nettype none
module acc_back #(
    parameter int FRAC_BITS = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire acc_pkg::cmd_t in_cmd,
    input  wire logic [11:0]   wheelbase,
    input  wire logic [6:0]    max_steer,
    input  wire logic [17:0]   raw_scale,
    input  wire logic          steer_inv,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         out_action,
    output logic [15:0]        out_mag,
    output logic signed [15:0] out_speed,
    output logic signed [7:0]  out_steer
);
    localparam int NS = (CORDIC_STAGES < acc_pkg::ANG_LEN) ? CORDIC_STAGES
                                                           : acc_pkg::ANG_LEN;
    // wide enough for the larger of the scaled speed and wheelbase * yaw
    localparam int XW = ((FRAC_BITS > 12) ? 16 + FRAC_BITS : 28) + 3;
    localparam int SH = FRAC_BITS + 8;
    localparam int NP = NS + 1;

    typedef struct packed {
        logic        stop;
        logic        neg;
        logic signed [15:0] speed;
        logic [16:0] mag;
    } side_t;

    logic                    adv;
    logic [NP-1:0]           vld_reg;
    side_t                   sd_reg [NP];
    logic signed [XW-1:0]    x_reg [NS+1];
    logic signed [XW-1:0]    y_reg [NS+1];
    logic signed [acc_pkg::ZW-1:0] z_reg [NS+1];
    logic [33:0]             prod_reg;
    logic                    ovalid_reg;
    logic [1:0]              act_reg;
    logic [15:0]             mag_reg;
    logic signed [15:0]      spd_reg;
    logic signed [7:0]       st_reg;
    logic signed [XW-1:0]    y0;
    logic [34:0]             rnd;
    side_t                   sd1_next;
    logic signed [acc_pkg::ZW-1:0] zf, zmax;
    logic [6:0]              cap;
    logic [acc_pkg::ZW-1:0]  za;
    logic [9:0]              qa;
    side_t                   last;

    // whole pipe moves when the output register is free
    assign adv = !ovalid_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        y0 = XW'($signed({1'b0, wheelbase}) * in_cmd.yaw);
        if (in_cmd.neg) y0 = -y0;
    end

    // rounded and saturated drive magnitude joins the side data at stage one
    always_comb begin
        rnd = 35'(prod_reg) + (35'd1 << (SH - 1));
        sd1_next = sd_reg[0];
        sd1_next.mag = ((rnd >> SH) > 35'(acc_pkg::MAG_LIMIT))
            ? acc_pkg::MAG_LIMIT : 17'(rnd >> SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NP-2:0], in_valid};
        end
        if (adv) begin
            sd_reg[0].stop <= in_cmd.stop;
            sd_reg[0].neg <= in_cmd.neg;
            sd_reg[0].speed <= in_cmd.speed;
            sd_reg[0].mag <= '0;
            prod_reg <= in_cmd.absv * raw_scale;
            x_reg[0] <= XW'({in_cmd.absv, FRAC_BITS'(0)});
            y_reg[0] <= y0;
            z_reg[0] <= '0;
            sd_reg[1] <= sd1_next;
            for (int k = 2; k < NP; k++) sd_reg[k] <= sd_reg[k-1];
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + acc_pkg::ang_tab(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - acc_pkg::ang_tab(i);
                end
            end
        end
    end

    // cordic output z_reg[NS] aligns with sd_reg[NS]
    always_comb begin
        last = sd_reg[NS];
        cap = (max_steer > acc_pkg::STEER_CAP) ? acc_pkg::STEER_CAP : max_steer;
        zmax = acc_pkg::ZW'({cap, 16'd0});
        zf = steer_inv ? -z_reg[NS] : z_reg[NS];
        if (zf > zmax) zf = zmax;
        if (zf < -zmax) zf = -zmax;
        za = zf[acc_pkg::ZW-1] ? acc_pkg::ZW'(-zf) : acc_pkg::ZW'(zf);
        qa = 10'((za + acc_pkg::ZW'(32768)) >> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (adv) begin
            ovalid_reg <= vld_reg[NS];
        end
        if (adv) begin
            if (last.stop) begin
                act_reg <= acc_pkg::ACT_STOP;
                mag_reg <= '0;
                spd_reg <= '0;
                st_reg <= '0;
            end else begin
                act_reg <= (last.mag == '0) ? acc_pkg::ACT_STOP
                         : (last.neg ? acc_pkg::ACT_REV : acc_pkg::ACT_FWD);
                mag_reg <= last.mag[15:0];
                spd_reg <= last.speed;
                st_reg <= zf[acc_pkg::ZW-1] ? -$signed(qa[7:0]) : $signed(qa[7:0]);
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_action = act_reg;
    assign out_mag = mag_reg;
    assign out_speed = spd_reg;
    assign out_steer = st_reg;
endmodule
`default_nettype wire

/* rtl/core/ackermann_command_converter_top.sv */
// top level of the ackermann command converter
// One velocity request in, one drive/steer result out. The block takes one
// request per cycle while m_ready does not hold a result: a front stage
// clamps speed and flags stop requests, a two-entry queue decouples it from
// the back end, and the back end runs an unrolled CORDIC with a register
// after each stage. Throughput is one request per cycle; a result held by
// m_ready low freezes the whole back end.
// Registers: 0 wheelbase, 1 max_speed, 2 speed_deadband, 3 max_steer_deg,
// 4 raw_scale, 5 steer_invert; write only while idle.
`default_nettype none
`include "ackermann_command_converter_top_macros.svh"
module ackermann_command_converter_top #(
    parameter int FRAC_BITS = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [17:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_linear_speed,
    input  wire logic signed [15:0] s_yaw_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_drive_action,
    output logic [15:0]             m_drive_magnitude,
    output logic signed [15:0]      m_limited_speed,
    output logic signed [7:0]       m_steer_degrees
);
    // configuration registers
    logic [11:0] wheelbase_reg;
    logic [14:0] max_speed_reg;
    logic [9:0]  deadband_reg;
    logic [6:0]  max_steer_reg;
    logic [17:0] raw_scale_reg;
    logic        steer_inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg <= 12'd676;
            max_speed_reg <= 15'd2273;
            deadband_reg <= 10'd10;
            max_steer_reg <= 7'd30;
            raw_scale_reg <= 18'd116352;
            steer_inv_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                acc_pkg::REG_WHEELBASE: wheelbase_reg <= cfg_data[11:0];
                acc_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[14:0];
                acc_pkg::REG_DEADBAND:  deadband_reg <= cfg_data[9:0];
                acc_pkg::REG_MAX_STEER: max_steer_reg <= cfg_data[6:0];
                acc_pkg::REG_RAW_SCALE: raw_scale_reg <= cfg_data;
                acc_pkg::REG_STEER_INV: steer_inv_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front to queue
    logic          f_valid, f_ready;
    acc_pkg::cmd_t f_cmd;
    // queue to back
    logic          q_valid, q_ready;
    acc_pkg::cmd_t q_cmd;

    acc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .speed(s_linear_speed), .yaw(s_yaw_rate),
        .max_speed(max_speed_reg), .deadband(deadband_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd)
    );

    acc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    acc_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
        .wheelbase(wheelbase_reg), .max_steer(max_steer_reg),
        .raw_scale(raw_scale_reg), .steer_inv(steer_inv_reg),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_action(m_drive_action), .out_mag(m_drive_magnitude),
        .out_speed(m_limited_speed), .out_steer(m_steer_degrees)
    );

    // a stop result carries a zero magnitude
    `ACC_ASSERT_IMP(a_stop_zero, aclk, aresetn,
        m_valid && m_drive_action == acc_pkg::ACT_STOP && m_drive_magnitude != 16'd0,
        1'b0, "stop result with nonzero magnitude")
    // a stalled result holds
    `ACC_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_steer_degrees), "result changed while stalled")
    // steering never exceeds the cap
    `ACC_ASSERT_IMP(a_cap, aclk, aresetn, m_valid,
        m_steer_degrees <= 8'sd89 && m_steer_degrees >= -8'sd89, "steer out of range")
endmodule
`default_nettype wire
